### hdl/jps_pkg.sv
// Shared types and constants for the Jacobi pressure stencil.
`default_nettype none
package jps_pkg;

	localparam int unsigned COL_BITS     = 10;
	localparam int unsigned ROW_BITS     = 16;
	localparam int unsigned GW_CFG_BITS  = 11;
	localparam int unsigned H2_BITS      = 32;
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS = 32;

	localparam logic [GW_CFG_BITS-1:0] GRID_WIDTH_RST  = 11'd514;
	localparam logic [ROW_BITS-1:0]    GRID_HEIGHT_RST = 16'd514;
	localparam logic [H2_BITS-1:0]     SPACING_SQ_RST  = 32'd655;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_SPACING_SQ  = 2'd2
	} cfg_reg_t;

	// position of the inner cell a result belongs to
	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                last;
	} cell_tag_t;

endpackage
`default_nettype wire

### hdl/jps_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module jps_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/jps_window.sv
// Raster counters, line stores and neighbor window; forms pressure and divergence sums.
`default_nettype none
module jps_window #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [jps_pkg::GW_CFG_BITS-1:0]        grid_width,
	input  wire logic [jps_pkg::ROW_BITS-1:0]           grid_height,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [3*VALUE_BITS-1:0]                in_cell,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [VALUE_BITS+1:0]                out_psum,
	output logic signed [VALUE_BITS+1:0]                out_dsum,
	output jps_pkg::cell_tag_t                          out_tag
);
	import jps_pkg::*;

	localparam int unsigned V   = VALUE_BITS;
	localparam int unsigned CEW = 3 * V;
	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned GW  = (CW + 1 > GW_CFG_BITS) ? CW + 1 : GW_CFG_BITS;
	localparam int unsigned XW  = (CW > COL_BITS) ? CW : COL_BITS;
	localparam int unsigned SW  = V + 2;

	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;

	logic          v_s1;
	logic          emit_s1;
	logic [CW-1:0] col_s1;
	logic [CEW-1:0] cur_s1;
	cell_tag_t     tag_s1;

	logic [CEW-1:0] win0_q, win1_q, win2_q, win3_q;
	logic [CEW-1:0] up_rd, mid_rd;

	logic [GW-1:0]       gw_ext, wd, wd_m1, c_ext;
	logic [ROW_BITS-1:0] ht, ht_m1;
	logic [XW-1:0]       cx;
	logic                col_end, emit, accept, leave1;
	cell_tag_t           tag;

	// geometry, clamped
	always_comb begin
		gw_ext = GW'(grid_width);
		if (gw_ext > GW'(MAX_WIDTH)) begin
			wd = GW'(MAX_WIDTH);
		end else if (gw_ext < GW'(3)) begin
			wd = GW'(3);
		end else begin
			wd = gw_ext;
		end
		wd_m1 = wd - GW'(1);
		ht    = (grid_height < ROW_BITS'(3)) ? ROW_BITS'(3) : grid_height;
		ht_m1 = ht - ROW_BITS'(1);
		c_ext = GW'(col_q);
		cx    = XW'(col_q);
		col_end = c_ext >= wd_m1;
		emit = (row_q >= ROW_BITS'(2)) && (row_q <= ht_m1) &&
			(c_ext >= GW'(2)) && (c_ext <= wd_m1);
		tag.row  = row_q - ROW_BITS'(1);
		tag.col  = COL_BITS'(cx - XW'(1));
		tag.last = (row_q == ht_m1) && (c_ext == wd_m1);
	end

	assign leave1   = v_s1 && (!emit_s1 || out_ready);
	assign in_ready = !v_s1 || leave1;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				if (col_end) begin
					col_q <= '0;
					row_q <= (row_q >= ht_m1) ? '0 : row_q + ROW_BITS'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (leave1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			col_s1  <= col_q;
			cur_s1  <= in_cell;
			tag_s1  <= tag;
		end
	end

	// window holds upper(c-1), middle(c-1), middle(c-2), input(c-1)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
			win3_q <= '0;
		end else if (leave1) begin
			win0_q <= up_rd;
			win1_q <= mid_rd;
			win2_q <= win1_q;
			win3_q <= cur_s1;
		end
	end

	// consecutive cells always hit different columns, so the write-back in
	// stage 1 never collides with the read of the next request
	jps_ram #(.WIDTH(CEW), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (leave1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	jps_ram #(.WIDTH(CEW), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (leave1),
		.waddr (col_s1),
		.wdata (cur_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// N = win0, S = win3, W = win2, E = middle read
	logic signed [SW-1:0] pn, ps, pw, pe, vxe, vxw, vys, vyn;

	always_comb begin
		pn  = SW'($signed(win0_q[3*V-1:2*V]));
		ps  = SW'($signed(win3_q[3*V-1:2*V]));
		pw  = SW'($signed(win2_q[3*V-1:2*V]));
		pe  = SW'($signed(mid_rd[3*V-1:2*V]));
		vxe = SW'($signed(mid_rd[V-1:0]));
		vxw = SW'($signed(win2_q[V-1:0]));
		vys = SW'($signed(win3_q[2*V-1:V]));
		vyn = SW'($signed(win0_q[2*V-1:V]));
		out_psum = pn + ps + pw + pe;
		out_dsum = (vxe - vxw) + (vys - vyn);
	end

	assign out_valid = v_s1 && emit_s1;
	assign out_tag   = tag_s1;

endmodule
`default_nettype wire

### hdl/jps_solve.sv
// Pressure update pipeline: divergence scaling, divide by four, saturation.
`default_nettype none
module jps_solve #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [jps_pkg::H2_BITS-1:0]      spacing_squared,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [VALUE_BITS+1:0]     in_psum,
	input  wire logic signed [VALUE_BITS+1:0]     in_dsum,
	input  wire jps_pkg::cell_tag_t               in_tag,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [VALUE_BITS-1:0]                 out_pressure,
	output jps_pkg::cell_tag_t                    out_tag
);
	import jps_pkg::*;

	localparam int unsigned V  = VALUE_BITS;
	localparam int unsigned SW = V + 2;
	localparam int unsigned DW = V + 1;
	localparam int unsigned DX = (DW > 33) ? DW : 33;
	localparam int unsigned HW = DX - 32;
	localparam int unsigned PW = HW + 32;
	localparam int unsigned YW = ((V + 2 > 57) ? V + 2 : 57) + 1;

	localparam logic signed [YW-1:0] VMAX_Y = {{(YW-V+1){1'b0}}, {(V-1){1'b1}}};
	localparam logic signed [YW-1:0] VMIN_Y = ~VMAX_Y;
	localparam logic [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
	localparam logic [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

	logic                 v_s2, v_s3, v_s4, out_valid_q;
	logic                 f3, f4, o_free;

	logic signed [SW-1:0] psum_s2, dsum_s2;
	cell_tag_t            tag_s2;

	logic signed [SW-1:0] psum_s3;
	logic [DW-1:0]        d_s3;
	logic                 neg_s3;
	cell_tag_t            tag_s3;

	logic signed [SW-1:0] psum_s4;
	logic [PW-1:0]        phi_s4;
	logic [63:0]          plo_s4;
	logic                 neg_s4;
	cell_tag_t            tag_s4;

	logic [V-1:0]         pres_q;
	cell_tag_t            tag_q;

	assign o_free   = !out_valid_q || out_ready;
	assign f4       = !v_s4 || o_free;
	assign f3       = !v_s3 || f4;
	assign in_ready = !v_s2 || f3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (f3) begin
				v_s3 <= v_s2;
			end
			if (f4) begin
				v_s4 <= v_s3;
			end
			if (o_free) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// stage 2: magnitude of twice the divergence
	logic          neg2;
	logic [DW-1:0] d2;

	always_comb begin
		neg2 = dsum_s2[SW-1];
		d2   = neg2 ? DW'(-dsum_s2) : DW'(dsum_s2);
	end

	// stage 3: split product |dsum| * h2
	logic [DX-1:0] dext;
	logic [HW-1:0] dhi;
	logic [31:0]   dlo;
	logic [PW-1:0] phi3;
	logic [63:0]   plo3;

	always_comb begin
		dext = DX'(d_s3);
		dhi  = dext[DX-1:32];
		dlo  = dext[31:0];
		phi3 = PW'(dhi) * PW'(spacing_squared);
		plo3 = 64'(dlo) * 64'(spacing_squared);
	end

	// stage 4: combine, floor divide by four, saturate
	logic [63:0]          phx;
	logic                 ovf, mr;
	logic [55:0]          mq;
	logic signed [YW-1:0] psx, mqx, y, q;
	logic [V-1:0]         res4;

	always_comb begin
		phx = 64'(phi_s4);
		ovf = |phx[63:40];
		mq  = 56'({phx[39:0], 15'b0}) + 56'(plo_s4[63:17]);
		mr  = |plo_s4[16:0];
		psx = YW'(psum_s4);
		mqx = $signed(YW'(mq));
		if (neg_s4) begin
			y = psx + mqx;
		end else begin
			y = psx - mqx - $signed(YW'(mr));
		end
		q = y >>> 2;
		if (ovf) begin
			res4 = neg_s4 ? VMAX : VMIN;
		end else if (q > VMAX_Y) begin
			res4 = VMAX;
		end else if (q < VMIN_Y) begin
			res4 = VMIN;
		end else begin
			res4 = q[V-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			psum_s2 <= in_psum;
			dsum_s2 <= in_dsum;
			tag_s2  <= in_tag;
		end
		if (f3 && v_s2) begin
			psum_s3 <= psum_s2;
			d_s3    <= d2;
			neg_s3  <= neg2;
			tag_s3  <= tag_s2;
		end
		if (f4 && v_s3) begin
			psum_s4 <= psum_s3;
			phi_s4  <= phi3;
			plo_s4  <= plo3;
			neg_s4  <= neg_s3;
			tag_s4  <= tag_s3;
		end
		if (o_free && v_s4) begin
			pres_q <= res4;
			tag_q  <= tag_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pressure = pres_q;
	assign out_tag      = tag_q;

endmodule
`default_nettype wire

### hdl/jacobi_pressure_stencil.sv
// Jacobi pressure stencil top level: stream ports, configuration registers.
// Throughput: one grid cell per cycle unless the master side stalls, bounded by
// the single read and single write port of each line store (one column read
// and written per cell). The request completing a neighborhood passes stages 1
// to 4 and the output register to the master side; border cells give no result.
// Reset clears counters, window and pipeline valids and loads the default
// geometry; line store contents are left as they are.
`default_nettype none
module jacobi_pressure_stencil #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// vel_x, vel_y, pressure_in, zero fill
	input  wire logic [((3*VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// new_pressure, cell_col, cell_row, zero fill
	output logic [((VALUE_BITS+26+7)/8)*8-1:0]         m_axis_tdata,
	output logic                                       m_axis_tlast,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [jps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [jps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import jps_pkg::*;

	localparam int unsigned V      = VALUE_BITS;
	localparam int unsigned TW_OUT = ((V + 26 + 7) / 8) * 8;

	logic [GW_CFG_BITS-1:0] grid_width_q;
	logic [ROW_BITS-1:0]    grid_height_q;
	logic [H2_BITS-1:0]     spacing_sq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			spacing_sq_q  <= SPACING_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[GW_CFG_BITS-1:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data[ROW_BITS-1:0];
				CFG_SPACING_SQ:  spacing_sq_q  <= cfg_data[H2_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic                 win_valid, win_ready;
	logic signed [V+1:0]  win_psum, win_dsum;
	cell_tag_t            win_tag;
	logic [V-1:0]         new_pressure;
	cell_tag_t            res_tag;

	jps_window #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_cell     (s_axis_tdata[3*V-1:0]),
		.out_valid   (win_valid),
		.out_ready   (win_ready),
		.out_psum    (win_psum),
		.out_dsum    (win_dsum),
		.out_tag     (win_tag)
	);

	jps_solve #(.VALUE_BITS(VALUE_BITS)) u_solve (
		.clk             (clk),
		.arst_n          (arst_n),
		.spacing_squared (spacing_sq_q),
		.in_valid        (win_valid),
		.in_ready        (win_ready),
		.in_psum         (win_psum),
		.in_dsum         (win_dsum),
		.in_tag          (win_tag),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_pressure    (new_pressure),
		.out_tag         (res_tag)
	);

	assign m_axis_tdata = TW_OUT'({res_tag.row, res_tag.col, new_pressure});
	assign m_axis_tlast = res_tag.last;

endmodule
`default_nettype wire
